// File: src/nma_pkg.sv
// Shared types and constants for the neuron MAC and activation block.
`timescale 1ns / 1ps
`default_nettype none

package nma_pkg;

  // Activation selection codes
  typedef enum logic [1:0] {
    ACT_SIGMOID = 2'd0,
    ACT_TANH    = 2'd1,
    ACT_RELU    = 2'd2,
    ACT_LEAKY   = 2'd3
  } act_kind_t;

  // Item classes produced by the front end
  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_CLOSE = 1'b1
  } op_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK     = 2'd2;

  localparam logic [7:0] LEAK_RESET = 8'd3;

  typedef struct packed {
    act_kind_t         kind;
    logic signed [15:0] bias;
    logic [7:0]        leak;
  } cfg_t;

  // Queue between front end and back end
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Fixed-point constants
  localparam logic [63:0] Q31_ONE = 64'h0000_0000_8000_0000;
  localparam logic [16:0] SIG_ONE = 17'h1_0000;

endpackage

`default_nettype wire

// File: src/nma_front.sv
// Front end: accepts input transactions, classifies them and hands them to the queue.
`timescale 1ns / 1ps
`default_nettype none

module nma_front import nma_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic signed [DATA_WIDTH-1:0] in_weight_value,
  input  logic                         in_is_last,
  input  q_status_t                    q_stat_i,
  output logic                         push_o,
  output logic [2*DATA_WIDTH:0]        push_data_o
);

  logic                  front_valid_r;
  op_t                   op_r;
  logic [DATA_WIDTH-1:0] x_r;
  logic [DATA_WIDTH-1:0] w_r;
  logic                  load;

  // Holding register drains into the queue whenever there is room
  assign push_o   = front_valid_r && !q_stat_i.full;
  assign in_ready = !front_valid_r || !q_stat_i.full;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (load) begin
      front_valid_r <= 1'b1;
    end else if (push_o) begin
      front_valid_r <= 1'b0;
    end
  end

  // Classify: the item marked last closes the evaluation
  always_ff @(posedge clk) begin
    if (load) begin
      op_r <= in_is_last ? OP_CLOSE : OP_ACCUM;
      x_r  <= in_value;
      w_r  <= in_weight_value;
    end
  end

  assign push_data_o = {op_r, x_r, w_r};

endmodule

`default_nettype wire

// File: src/nma_queue.sv
// Short FIFO that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module nma_queue import nma_pkg::*; #(
  parameter int W = 33
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o,
  output q_status_t    q_stat_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [W-1:0]     mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push;
  logic             do_pop;

  assign q_stat_o.full  = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign q_stat_o.empty = (cnt_r == '0);
  assign do_push = push_i && !q_stat_o.full;
  assign do_pop  = pop_i && !q_stat_o.empty;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  assign pop_data_o = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// File: src/nma_back.sv
// Back end: multiply-accumulate, bias, rounding, activation lookup and output register.
`timescale 1ns / 1ps
`default_nettype none

module nma_back import nma_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 40,
  parameter int LUT_DEPTH  = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg_i,
  input  q_status_t           q_stat_i,
  output logic                pop_o,
  input  logic [2*DATA_WIDTH:0] pop_data_i,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  out_pre_activation,
  output logic signed [15:0]  out_activation_out,
  output logic signed [15:0]  out_derivative_out,
  output logic                out_saturated
);

  localparam int PW    = 2 * DATA_WIDTH;
  localparam int SW    = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;
  localparam int BW    = ACC_WIDTH + 1;
  localparam int IDX_W = $clog2(LUT_DEPTH);
  localparam int MW    = 25 + IDX_W + 1;

  localparam logic signed [SW-1:0] ACC_HI = {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;
  localparam logic signed [BW-1:0] RND_HALF = BW'(128);
  localparam logic signed [BW-1:0] PRE_HI = BW'(24'sh7f_ffff);
  localparam logic signed [BW-1:0] PRE_LO = ~PRE_HI;
  localparam logic [MW-1:0] LUT_LEN = MW'(LUT_DEPTH);
  localparam logic [40:0] DER_RND  = 41'h0_0080_0000;
  localparam logic [40:0] TANH_ONE = 41'h1_0000_0000;
  localparam logic signed [25:0] ACT_HI = 26'sd32767;
  localparam logic signed [25:0] ACT_LO = -26'sd32768;

  // ---------------------------------------------------------------
  // Sigmoid table, Q0.16, built at elaboration
  // ---------------------------------------------------------------
  function automatic logic [63:0] div_small(input logic [63:0] v, input int n);
    case (n)
      2:       return v / 64'd2;
      3:       return v / 64'd3;
      4:       return v / 64'd4;
      5:       return v / 64'd5;
      6:       return v / 64'd6;
      7:       return v / 64'd7;
      8:       return v / 64'd8;
      9:       return v / 64'd9;
      10:      return v / 64'd10;
      11:      return v / 64'd11;
      12:      return v / 64'd12;
      default: return v;
    endcase
  endfunction

  // e^-x via a 12-term series at x/16 then four squarings; 1/(1+e^-x) by long division
  function automatic logic [15:0] sig_entry(input int unsigned idx);
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    t    = (64'(idx) << 30) / LUT_DEPTH;
    sum  = Q31_ONE;
    term = Q31_ONE;
    for (int n = 1; n <= 12; n++) begin
      term = div_small((term * t) >> 31, n);
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int k = 0; k < 4; k++) begin
      sum = (sum * sum) >> 31;
    end
    den = Q31_ONE + sum;
    num = (64'd1 << 47) + (den >> 1);
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo[15:0];
  endfunction

  logic [15:0] sig_rom [LUT_DEPTH];

  for (genvar g = 0; g < LUT_DEPTH; g++) begin : g_rom
    localparam logic [15:0] SIG_VAL = sig_entry(g);
    assign sig_rom[g] = SIG_VAL;
  end

  // ---------------------------------------------------------------
  // Pipeline advance: everything moves unless the output is held
  // ---------------------------------------------------------------
  logic adv;
  assign adv   = !out_valid || out_ready;
  assign pop_o = adv && !q_stat_i.empty;

  op_t                         pop_op;
  logic signed [DATA_WIDTH-1:0] pop_x;
  logic signed [DATA_WIDTH-1:0] pop_w;
  assign pop_op = op_t'(pop_data_i[PW]);
  assign pop_x  = $signed(pop_data_i[PW-1:DATA_WIDTH]);
  assign pop_w  = $signed(pop_data_i[DATA_WIDTH-1:0]);

  // Stage valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, out_valid_r;

  // Stage 1: product
  logic signed [PW-1:0] prod1_r;
  logic                 last1_r;

  // Stage 2: accumulator
  logic signed [ACC_WIDTH-1:0] acc_r;
  logic                        acc_clip_r;
  logic signed [SW-1:0]        acc_sum;
  logic signed [ACC_WIDTH-1:0] acc_sat;
  logic                        acc_clip;
  logic signed [ACC_WIDTH-1:0] sum2_r;
  logic                        clip2_r;

  // Stage 3: bias
  logic signed [23:0]          bias_ext;
  logic signed [BW-1:0]        bias_sum;
  logic signed [ACC_WIDTH-1:0] bias_sat;
  logic                        bias_clip;
  logic signed [ACC_WIDTH-1:0] sum3_r;
  logic                        clip3_r;

  // Stage 4: round to Q15.8
  logic signed [BW-1:0] rnd_full;
  logic signed [BW-1:0] rnd;
  logic signed [23:0]   pre_sat;
  logic                 pre_clip;
  logic signed [23:0]   pre4_r;
  logic                 clip4_r;

  // Stage 5: magnitude and table index
  logic            neg;
  logic [23:0]     mag;
  logic [24:0]     m2;
  logic [MW-1:0]   scaled;
  logic [MW-1:0]   idx_full;
  logic            neg5_r, pos5_r, over5_r, clip5_r;
  logic [23:0]     mag5_r;
  logic signed [23:0] pre5_r;
  logic [IDX_W-1:0] idx5_r;

  // Stage 6: table read
  logic [15:0]     rom_q_r;
  logic            neg6_r, pos6_r, over6_r, clip6_r;
  logic [23:0]     mag6_r;
  logic signed [23:0] pre6_r;

  // Stage 7: multiplier operands
  logic [16:0]     s;
  logic [16:0]     sg;
  logic [17:0]     t18;
  logic [16:0]     t;
  logic [17:0]     rnd_act;
  logic [23:0]     op_a;
  logic [16:0]     op_b;
  logic [8:0]      amag;
  logic [23:0]     a7_r;
  logic [16:0]     b7_r;
  logic [8:0]      amag7_r;
  logic            neg7_r, pos7_r, clip7_r;
  logic signed [23:0] pre7_r;

  // Stage 8: product
  logic [40:0]     mp8_r;
  logic [8:0]      amag8_r;
  logic            neg8_r, pos8_r, clip8_r;
  logic signed [23:0] pre8_r;

  // Output stage
  logic signed [25:0] act_w;
  logic [40:0]        der_full;
  logic [40:0]        lk;
  logic [15:0]        der_w;
  logic signed [15:0] act_sat;
  logic               act_clip;
  logic signed [23:0] out_pre_r;
  logic signed [15:0] out_act_r;
  logic [15:0]        out_der_r;
  logic               out_sat_r;

  // Valid chain and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      acc_clip_r  <= 1'b0;
    end else if (adv) begin
      v1_r        <= pop_o;
      v2_r        <= v1_r && last1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      out_valid_r <= v8_r;
      if (v1_r) begin
        acc_r      <= last1_r ? '0 : acc_sat;
        acc_clip_r <= last1_r ? 1'b0 : acc_clip;
      end
    end
  end

  // Stage 1: multiply the pair
  always_ff @(posedge clk) begin
    if (adv) begin
      prod1_r <= pop_x * pop_w;
      last1_r <= (pop_op == OP_CLOSE);
    end
  end

  // Stage 2: saturating accumulate
  always_comb begin
    acc_sum  = SW'(acc_r) + SW'(prod1_r);
    acc_clip = acc_clip_r;
    if (acc_sum > ACC_HI) begin
      acc_sat  = ACC_HI[ACC_WIDTH-1:0];
      acc_clip = 1'b1;
    end else if (acc_sum < ACC_LO) begin
      acc_sat  = ACC_LO[ACC_WIDTH-1:0];
      acc_clip = 1'b1;
    end else begin
      acc_sat = acc_sum[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum2_r  <= acc_sat;
      clip2_r <= acc_clip;
    end
  end

  // Stage 3: add bias, saturate at accumulator width
  always_comb begin
    bias_ext  = $signed({cfg_i.bias, 8'h00});
    bias_sum  = BW'(sum2_r) + BW'(bias_ext);
    bias_clip = clip2_r;
    if (bias_sum > ACC_HI) begin
      bias_sat  = ACC_HI[ACC_WIDTH-1:0];
      bias_clip = 1'b1;
    end else if (bias_sum < ACC_LO) begin
      bias_sat  = ACC_LO[ACC_WIDTH-1:0];
      bias_clip = 1'b1;
    end else begin
      bias_sat = bias_sum[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum3_r  <= bias_sat;
      clip3_r <= bias_clip;
    end
  end

  // Stage 4: round half up to Q15.8 and saturate to 24 bits
  always_comb begin
    rnd_full = BW'(sum3_r) + RND_HALF;
    rnd      = rnd_full >>> 8;
    pre_clip = clip3_r;
    if (rnd > PRE_HI) begin
      pre_sat  = 24'sh7f_ffff;
      pre_clip = 1'b1;
    end else if (rnd < PRE_LO) begin
      pre_sat  = -24'sh80_0000;
      pre_clip = 1'b1;
    end else begin
      pre_sat = rnd[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre4_r  <= pre_sat;
      clip4_r <= pre_clip;
    end
  end

  // Stage 5: magnitude and table index (tanh looks up sigmoid at 2x)
  always_comb begin
    neg      = pre4_r[23];
    mag      = neg ? (~pre4_r + 24'd1) : pre4_r;
    m2       = (cfg_i.kind == ACT_TANH) ? {mag, 1'b0} : {1'b0, mag};
    scaled   = MW'(m2) * LUT_LEN;
    idx_full = scaled >> 11;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg5_r  <= neg;
      pos5_r  <= !neg && (pre4_r != '0);
      mag5_r  <= mag;
      pre5_r  <= pre4_r;
      over5_r <= (idx_full >= LUT_LEN);
      idx5_r  <= idx_full[IDX_W-1:0];
      clip5_r <= clip4_r;
    end
  end

  // Stage 6: registered table read
  always_ff @(posedge clk) begin
    if (adv) begin
      rom_q_r <= sig_rom[idx5_r];
      neg6_r  <= neg5_r;
      pos6_r  <= pos5_r;
      mag6_r  <= mag5_r;
      pre6_r  <= pre5_r;
      over6_r <= over5_r;
      clip6_r <= clip5_r;
    end
  end

  // Stage 7: sigmoid/tanh values and multiplier operands
  always_comb begin
    s       = over6_r ? SIG_ONE : {1'b0, rom_q_r};
    sg      = neg6_r ? (SIG_ONE - s) : s;
    t18     = {s, 1'b0} - {1'b0, SIG_ONE};
    t       = t18[16:0];
    rnd_act = '0;
    case (cfg_i.kind)
      ACT_SIGMOID: begin
        op_a    = 24'(sg);
        op_b    = SIG_ONE - sg;
        rnd_act = (18'(sg) + 18'd128) >> 8;
      end
      ACT_TANH: begin
        op_a    = 24'(t);
        op_b    = t;
        rnd_act = (18'(t) + 18'd128) >> 8;
      end
      default: begin
        op_a = mag6_r;
        op_b = {9'd0, cfg_i.leak};
      end
    endcase
    amag = rnd_act[8:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a7_r    <= op_a;
      b7_r    <= op_b;
      amag7_r <= amag;
      neg7_r  <= neg6_r;
      pos7_r  <= pos6_r;
      pre7_r  <= pre6_r;
      clip7_r <= clip6_r;
    end
  end

  // Stage 8: one multiply
  always_ff @(posedge clk) begin
    if (adv) begin
      mp8_r   <= 41'(a7_r) * 41'(b7_r);
      amag8_r <= amag7_r;
      neg8_r  <= neg7_r;
      pos8_r  <= pos7_r;
      pre8_r  <= pre7_r;
      clip8_r <= clip7_r;
    end
  end

  // Output stage: activation, derivative, final saturation
  always_comb begin
    act_w    = '0;
    der_full = '0;
    lk       = (mp8_r + 41'd128) >> 8;
    der_w    = '0;
    case (cfg_i.kind)
      ACT_SIGMOID: begin
        act_w    = $signed(26'(amag8_r));
        der_full = (mp8_r + DER_RND) >> 24;
        der_w    = der_full[15:0];
      end
      ACT_TANH: begin
        act_w    = neg8_r ? -$signed(26'(amag8_r)) : $signed(26'(amag8_r));
        der_full = (TANH_ONE - mp8_r + DER_RND) >> 24;
        der_w    = der_full[15:0];
      end
      ACT_RELU: begin
        if (pos8_r) begin
          act_w = 26'(pre8_r);
          der_w = 16'd256;
        end
      end
      default: begin
        if (pos8_r) begin
          act_w = 26'(pre8_r);
          der_w = 16'd256;
        end else begin
          act_w = -$signed({1'b0, lk[24:0]});
          der_w = {8'h00, cfg_i.leak};
        end
      end
    endcase
    act_clip = clip8_r;
    if (act_w > ACT_HI) begin
      act_sat  = 16'sh7fff;
      act_clip = 1'b1;
    end else if (act_w < ACT_LO) begin
      act_sat  = -16'sh8000;
      act_clip = 1'b1;
    end else begin
      act_sat = act_w[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pre_r <= pre8_r;
      out_act_r <= act_sat;
      out_der_r <= der_w;
      out_sat_r <= act_clip;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pre_activation = out_pre_r;
  assign out_activation_out = out_act_r;
  assign out_derivative_out = $signed(out_der_r);
  assign out_saturated      = out_sat_r;

endmodule

`default_nettype wire

// File: src/neuron_mac_activation_top.sv
// Top level of the neuron MAC and activation block.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------------
//  in_     | input     | in_valid/in_ready  | in_value, in_weight_value, in_is_last
//  out_    | output    | out_valid/out_ready| pre_activation, activation_out,
//          |           |                    | derivative_out, saturated
//  cfg_    | input     | cfg_we (no stall)  | cfg_index, cfg_data
//
//  One (value, weight) pair per cycle sustained while the output is not stalled;
//  the saturating accumulate loop around acc_r sets that rate. A closing pair
//  moves through the front register, a queue slot, eight back-end stages and
//  the output register, which raises out_valid, and is taken at the next edge
//  when out_ready is high. Reset is synchronous and clears the accumulator,
//  queue and pipeline valids. An output stall freezes the back end; the 4-entry
//  queue and front register keep accepting input until they fill.
`timescale 1ns / 1ps
`default_nettype none

module neuron_mac_activation_top import nma_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 40,
  parameter int LUT_DEPTH  = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic signed [DATA_WIDTH-1:0] in_weight_value,
  input  logic                         in_is_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [23:0]           out_pre_activation,
  output logic signed [15:0]           out_activation_out,
  output logic signed [15:0]           out_derivative_out,
  output logic                         out_saturated,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int QW = 2 * DATA_WIDTH + 1;

  cfg_t            cfg_r;
  q_status_t       q_stat;
  logic            push;
  logic [QW-1:0]   push_data;
  logic            pop;
  logic [QW-1:0]   pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind <= ACT_SIGMOID;
      cfg_r.bias <= '0;
      cfg_r.leak <= LEAK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACT_KIND: cfg_r.kind <= act_kind_t'(cfg_data[1:0]);
        CFG_BIAS:     cfg_r.bias <= $signed(cfg_data);
        CFG_LEAK:     cfg_r.leak <= cfg_data[7:0];
        default:      cfg_r      <= cfg_r;
      endcase
    end
  end

  nma_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .in_weight_value (in_weight_value),
    .in_is_last      (in_is_last),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  nma_queue #(
    .W (QW)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .q_stat_o    (q_stat)
  );

  nma_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH),
    .LUT_DEPTH  (LUT_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_i              (cfg_r),
    .q_stat_i           (q_stat),
    .pop_o              (pop),
    .pop_data_i         (pop_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pre_activation (out_pre_activation),
    .out_activation_out (out_activation_out),
    .out_derivative_out (out_derivative_out),
    .out_saturated      (out_saturated)
  );

endmodule

`default_nettype wire

// File: src/nma_checker.sv
// Port-level assertions for the neuron MAC and activation block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nma_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_is_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] out_pre_activation,
  input logic signed [15:0] out_activation_out,
  input logic signed [15:0] out_derivative_out,
  input logic               out_saturated
);

  // Closing transactions accepted but not yet delivered
  logic [5:0] pend_r;
  logic [5:0] pend_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if (in_valid && in_ready && in_is_last) begin
      pend_nxt = pend_nxt + 6'd1;
    end
    if (out_valid && out_ready) begin
      pend_nxt = pend_nxt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pre_activation) &&
      $stable(out_activation_out) && $stable(out_derivative_out) && $stable(out_saturated))
    else $error("result changed while stalled");

  // Reset empties the pipeline and opens the input
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // No result without an earlier closing transaction
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 6'd0)
    else $error("result without a closing transaction");

  // Derivatives of all activations lie in [0, 1]
  a_der_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_derivative_out[15] && (out_derivative_out <= 16'sd256))
    else $error("derivative out of range");

endmodule

bind neuron_mac_activation_top nma_checker u_nma_checker (.*);

`default_nettype wire

// File: dv/neuron_eval_checker.sv
// Checker for the neuron MAC and activation block: predicts each result and compares it.
`timescale 1ns / 1ps

module neuron_eval_checker import nma_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 40,
  parameter int LUT_DEPTH  = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic signed [DATA_WIDTH-1:0] in_weight_value,
  input  logic                         in_is_last,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [23:0]           out_pre_activation,
  input  logic signed [15:0]           out_activation_out,
  input  logic signed [15:0]           out_derivative_out,
  input  logic                         out_saturated,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output int                           outstanding,
  output int                           error_count
);

  typedef struct packed {
    logic signed [23:0] pre;
    logic signed [15:0] act;
    logic signed [15:0] der;
    logic               sat;
  } neuron_result_t;

  localparam longint ACC_MAX   = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
  localparam longint ACC_MIN   = -ACC_MAX - 1;
  localparam longint PRE_MAX   = 64'sd8388607;
  localparam longint PRE_MIN   = -64'sd8388608;
  localparam longint ACT_MAX   = 64'sd32767;
  localparam longint ACT_MIN   = -64'sd32768;
  localparam longint SIG_UNITY = 64'sd65536;
  localparam longint ONE_Q32   = 64'sd4294967296;
  localparam longint HALF_Q24  = 64'sd8388608;
  localparam longint unsigned ONE_Q31 = 64'd2147483648;

  logic [16:0]    sig_lut [LUT_DEPTH];
  cfg_t           setting;
  longint         running;
  bit             acc_clipped;
  neuron_result_t result_q[$];
  neuron_result_t want;
  int             fails = 0;

  // Sigmoid at x = 8*i/LUT_DEPTH in Q0.16, via e^-x = (e^-(x/16))^16 and a Taylor series
  function automatic longint sigmoid_entry(int unsigned i);
    longint unsigned t, total, term, den;
    t     = (longint'(i) << 30) / LUT_DEPTH;
    total = ONE_Q31;
    term  = ONE_Q31;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * t) >> 31) / n;
      if (n % 2 == 1) total -= term;
      else total += term;
    end
    repeat (4) total = (total * total) >> 31;
    den = ONE_Q31 + total;
    return longint'(((64'd1 << 47) + den / 2) / den);
  endfunction

  initial begin
    for (int i = 0; i < LUT_DEPTH; i++) sig_lut[i] = 17'(sigmoid_entry(i));
  end

  // Sigmoid of a Q15.8 magnitude, Q0.16; saturates to one past the table
  function automatic longint sig_of(longint mag);
    longint idx;
    idx = (mag * LUT_DEPTH) / 2048;
    if (idx >= LUT_DEPTH) return SIG_UNITY;
    return longint'(sig_lut[idx]);
  endfunction

  // Closing step: bias, rounding to Q15.8, activation and derivative
  function automatic neuron_result_t close_eval(longint total, bit clipped);
    neuron_result_t res;
    longint s, q, r, pre, mag, sg, tv, m, act, der;
    bit clip;
    clip = clipped;
    act  = 0;
    der  = 0;
    s = total + longint'($signed(setting.bias)) * 256;
    if (s > ACC_MAX) begin
      s    = ACC_MAX;
      clip = 1'b1;
    end else if (s < ACC_MIN) begin
      s    = ACC_MIN;
      clip = 1'b1;
    end
    // round half up
    q = s >>> 8;
    r = s - q * 256;
    if (r >= 128) q = q + 1;
    pre = q;
    if (pre > PRE_MAX) begin
      pre  = PRE_MAX;
      clip = 1'b1;
    end else if (pre < PRE_MIN) begin
      pre  = PRE_MIN;
      clip = 1'b1;
    end
    mag = (pre < 0) ? -pre : pre;
    case (setting.kind)
      ACT_SIGMOID: begin
        sg = sig_of(mag);
        if (pre < 0) sg = SIG_UNITY - sg;
        act = (sg + 128) >>> 8;
        der = (sg * (SIG_UNITY - sg) + HALF_Q24) >>> 24;
      end
      ACT_TANH: begin
        tv  = 2 * sig_of(2 * mag) - SIG_UNITY;
        m   = (tv + 128) >>> 8;
        act = (pre < 0) ? -m : m;
        der = (ONE_Q32 - tv * tv + HALF_Q24) >>> 24;
      end
      ACT_RELU: begin
        if (pre > 0) begin
          act = pre;
          der = 256;
        end
      end
      default: begin
        if (pre > 0) begin
          act = pre;
          der = 256;
        end else begin
          act = -((mag * longint'(setting.leak) + 128) >>> 8);
          der = longint'(setting.leak);
        end
      end
    endcase
    if (act > ACT_MAX) begin
      act  = ACT_MAX;
      clip = 1'b1;
    end else if (act < ACT_MIN) begin
      act  = ACT_MIN;
      clip = 1'b1;
    end
    res.pre = pre[23:0];
    res.act = act[15:0];
    res.der = der[15:0];
    res.sat = clip;
    return res;
  endfunction

  task automatic check_field(string field, longint exp_val, longint got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, actual %0d", field, exp_val, got_val);
      fails++;
    end
  endtask

  // Track configuration, accumulate, and compare results in order
  always @(posedge clk) begin
    if (!rst_n) begin
      setting.kind = ACT_SIGMOID;
      setting.bias = '0;
      setting.leak = LEAK_RESET;
      running      = 0;
      acc_clipped  = 1'b0;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result transaction with nothing pending: pre_activation %0d",
                 out_pre_activation);
          fails++;
        end else begin
          want = result_q.pop_front();
          check_field("pre_activation", want.pre, out_pre_activation);
          check_field("activation_out", want.act, out_activation_out);
          check_field("derivative_out", want.der, out_derivative_out);
          check_field("saturated", want.sat, out_saturated);
        end
      end
      if (in_valid && in_ready) begin
        running = running + longint'(in_value) * longint'(in_weight_value);
        if (running > ACC_MAX) begin
          running     = ACC_MAX;
          acc_clipped = 1'b1;
        end else if (running < ACC_MIN) begin
          running     = ACC_MIN;
          acc_clipped = 1'b1;
        end
        if (in_is_last) begin
          result_q    = {result_q, close_eval(running, acc_clipped)};
          running     = 0;
          acc_clipped = 1'b0;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACT_KIND: setting.kind = act_kind_t'(cfg_data[1:0]);
          CFG_BIAS:     setting.bias = cfg_data[15:0];
          CFG_LEAK:     setting.leak = cfg_data[7:0];
          default:      ;
        endcase
      end
    end
    outstanding <= result_q.size();
    error_count <= fails;
  end

endmodule

// File: dv/testbench.sv
// Testbench top for the neuron MAC and activation block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module testbench;
  import nma_pkg::*;

  localparam int DATA_W         = 16;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_PAIRS    = 27;
  localparam int CALM_PHASES    = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_value;
  logic signed [DATA_W-1:0] in_weight_value;
  logic                     in_is_last;
  logic                     out_valid;
  logic                     out_ready = 1'b1;
  logic signed [23:0]       out_pre_activation;
  logic signed [15:0]       out_activation_out;
  logic signed [15:0]       out_derivative_out;
  logic                     out_saturated;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  int outstanding;
  int error_count;
  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int pairs_sent = 0;
  int evals_sent = 0;
  int settings_used = 0;

  neuron_mac_activation_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_value           (in_value),
    .in_weight_value    (in_weight_value),
    .in_is_last         (in_is_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pre_activation (out_pre_activation),
    .out_activation_out (out_activation_out),
    .out_derivative_out (out_derivative_out),
    .out_saturated      (out_saturated),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  neuron_eval_checker result_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_value           (in_value),
    .in_weight_value    (in_weight_value),
    .in_is_last         (in_is_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pre_activation (out_pre_activation),
    .out_activation_out (out_activation_out),
    .out_derivative_out (out_derivative_out),
    .out_saturated      (out_saturated),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .outstanding        (outstanding),
    .error_count        (error_count)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Output backpressure: random bursts with out_ready held low
  always @(posedge clk) begin
    if (!out_ready && stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_ready && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: too long without any transaction ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Operand mix: mostly within the sigmoid range, some full scale and corner values
  function automatic logic [15:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 16'($urandom_range(0, 2047)) - 16'd1024;
    if (sel < 6) return 16'($urandom_range(0, 127)) - 16'd64;
    if (sel < 8) return 16'($urandom);
    case ($urandom_range(0, 4))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // One input transaction, with an optional idle burst ahead of it
  task automatic send_pair(logic [15:0] v, logic [15:0] w, op_t op);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_value        <= v;
    in_weight_value <= w;
    in_is_last      <= (op == OP_CLOSE);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
    if (op == OP_CLOSE) evals_sent++;
  endtask

  // Drop valid, wait for all results, then let trailing accumulate work drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers plus the unused index; upper data bits are junk
  task automatic set_config(act_kind_t kind, logic [15:0] bias, logic [7:0] leak);
    logic [15:0] junk;
    junk = 16'($urandom);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACT_KIND;
    cfg_data  <= {junk[15:2], kind};
    @(posedge clk);
    cfg_index <= CFG_BIAS;
    cfg_data  <= bias;
    @(posedge clk);
    cfg_index <= CFG_LEAK;
    cfg_data  <= {junk[15:8], leak};
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= ~junk;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Random evaluations of mostly short length
  task automatic run_evaluations(int unsigned target);
    int unsigned sent, len;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      for (int unsigned k = 0; k < len; k++)
        send_pair(pick_operand(), pick_operand(), (k == len - 1) ? OP_CLOSE : OP_ACCUM);
      sent += len;
    end
  endtask

  initial begin
    act_kind_t   kind;
    logic [15:0] bias;
    logic [7:0]  leak;
    int          pick;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_value        <= '0;
    in_weight_value <= '0;
    in_is_last      <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_ACT_KIND;
    cfg_data        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings (sigmoid), table edges, rounding, pre-activation clip
    send_pair(16'sd0, 16'sd0, OP_CLOSE);
    send_pair(16'sd2047, 16'sd256, OP_CLOSE);
    send_pair(-16'sd2048, 16'sd256, OP_CLOSE);
    send_pair(16'h7FFF, 16'h7FFF, OP_ACCUM);
    send_pair(16'h8000, 16'h8000, OP_ACCUM);
    send_pair(16'h7FFF, 16'h7FFF, OP_CLOSE);
    send_pair(16'sd128, 16'sd1, OP_CLOSE);
    send_pair(-16'sd128, 16'sd1, OP_CLOSE);

    // tanh around the table edge and negative input
    set_config(ACT_TANH, 16'h0000, LEAK_RESET);
    send_pair(16'sd1023, 16'sd256, OP_CLOSE);
    send_pair(-16'sd1024, 16'sd256, OP_CLOSE);
    send_pair(-16'sd300, 16'sd256, OP_CLOSE);

    // relu with max bias: activation clip and negative side
    set_config(ACT_RELU, 16'h7FFF, 8'd0);
    send_pair(16'sd0, 16'sd0, OP_CLOSE);
    send_pair(16'h7FFF, 16'h7FFF, OP_CLOSE);
    send_pair(16'h8000, 16'h7FFF, OP_CLOSE);

    // leaky relu: zero input, negative clip, plain negative slope
    set_config(ACT_LEAKY, 16'h0000, 8'd255);
    send_pair(16'sd0, 16'sd0, OP_CLOSE);
    send_pair(16'h8000, 16'h7FFF, OP_ACCUM);
    send_pair(16'h8000, 16'h7FFF, OP_CLOSE);
    send_pair(-16'sd512, 16'sd256, OP_CLOSE);
    set_config(ACT_LEAKY, 16'h8000, 8'd0);
    send_pair(16'sd0, 16'sd0, OP_CLOSE);

    // relu exactly at zero
    set_config(ACT_RELU, 16'h0000, LEAK_RESET);
    send_pair(16'sd0, 16'sd0, OP_CLOSE);

    // Random phases, one register setting each; the last phases run without idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      kind = act_kind_t'(ph % 4);
      case (ph % 5)
        0:       bias = 16'h8000;
        1:       bias = 16'h7FFF;
        2:       bias = 16'h0000;
        default: bias = 16'($urandom_range(0, 2047)) - 16'd1024;
      endcase
      case (ph % 3)
        0:       leak = 8'd0;
        1:       leak = 8'd255;
        default: leak = 8'($urandom);
      endcase
      if (ph == 4) bias = 16'h7FFF;
      if (ph == 9) bias = 16'h8000;
      set_config(kind, bias, leak);
      if (ph >= RANDOM_PHASES - CALM_PHASES) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        pick      = $urandom_range(0, 2);
        gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
        pick      = $urandom_range(0, 2);
        stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
      end
      run_evaluations(PHASE_PAIRS);
    end

    drain();
    $display("Covered %0d pairs in %0d neuron evaluations over %0d register settings,",
             pairs_sent, evals_sent, settings_used + 1);
    $display("all four activations, pre-activation and activation clipping, stalls on both sides.");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
